// ----- hw/rtl/oaht_pkg.sv -----
`timescale 1ns / 1ps

package oaht_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;

    localparam logic [KEY_W-1:0] KEY_EMPTY   = '0;
    localparam logic [KEY_W-1:0] KEY_DELETED = '1;

    // home slot reduction takes two key bits per cycle
    localparam int MOD_DIGIT_W = 2;
    localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RESERVED  = 2'd3
    } t_status;

endpackage

// ----- hw/rtl/open_addressing_hash_table.sv -----
`timescale 1ns / 1ps

// Open-addressing key/value table with tombstones, keys and values in two
// single-port-write RAMs. A request is taken when start is high and busy is
// low; its result shows on o_status/o_found_value for one cycle with o_strobe
// and cannot be held off. After reset the key RAM is swept to empty, one slot
// a cycle, with busy high until the sweep ends. A reserved key or the no-op
// action answers on the next cycle. Otherwise the key is first reduced to its
// home slot (a mask of the low key bits when TABLE_SLOTS is a power of two,
// else a serial reduction taking two key bits per cycle), then each probed
// slot takes a RAM read and a compare, so the time grows with table load and
// probe chain length.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_action,
    input  logic [KEY_W-1:0] i_entry_key,
    input  logic [VAL_W-1:0] i_entry_value,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [VAL_W-1:0] o_found_value
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int NW = $clog2(TABLE_SLOTS + 1);
    localparam logic [AW:0]   N_SUM  = (AW+1)'(TABLE_SLOTS);
    localparam logic [NW-1:0] N_CNT  = NW'(TABLE_SLOTS);
    localparam logic [AW-1:0] LAST_A = AW'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_action           r_action;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [AW-1:0]     r_slot, n_slot;
    logic [NW-1:0]     r_n, n_n;
    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [VAL_W-1:0]  r_found, n_found;

    logic              accept;
    logic              reserved;
    logic              mod_start;
    logic              mod_done;
    logic [AW-1:0]     mod_rem;
    logic              key_we;
    logic [KEY_W-1:0]  key_wdata;
    logic [KEY_W-1:0]  key_rd;
    logic              val_we;
    logic [VAL_W-1:0]  val_rd;
    logic [AW:0]       step_sum;
    logic [AW-1:0]     next_slot;
    logic              slot_free;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign reserved = (i_entry_key == KEY_EMPTY) || (i_entry_key == KEY_DELETED);
    assign mod_start = accept && (t_action'(i_action) != ACT_NOP) && !reserved;

    oaht_mod #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_key  (i_entry_key),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    oaht_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_slot),
        .i_wdata(key_wdata),
        .i_raddr(r_slot),
        .o_rdata(key_rd)
    );

    oaht_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_SLOTS)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(r_slot),
        .i_wdata(r_value),
        .i_raddr(r_slot),
        .o_rdata(val_rd)
    );

    // slot + n stays below twice the slot count
    always_comb begin
        step_sum = {1'b0, r_slot} + (AW+1)'(r_n);
        if (step_sum >= N_SUM) begin
            step_sum = step_sum - N_SUM;
        end
        next_slot = step_sum[AW-1:0];
    end

    assign slot_free = (key_rd == KEY_EMPTY) || (key_rd == KEY_DELETED);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_n       = r_n;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        key_we    = 1'b0;
        key_wdata = KEY_EMPTY;
        val_we    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                key_we = 1'b1;
                n_slot = r_slot + 1'b1;
                if (r_slot == LAST_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_found = '0;
                    if (t_action'(i_action) == ACT_NOP) begin
                        n_strobe = 1'b1;
                        n_status = ST_DONE;
                    end else if (reserved) begin
                        n_strobe = 1'b1;
                        n_status = ST_RESERVED;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_slot  = mod_rem;
                    n_n     = NW'(1);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_action == ACT_INSERT && slot_free) begin
                    key_we    = 1'b1;
                    key_wdata = r_key;
                    val_we    = 1'b1;
                    n_strobe  = 1'b1;
                    n_status  = ST_DONE;
                    n_state   = S_IDLE;
                end else if (r_action != ACT_INSERT && key_rd == KEY_EMPTY) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else if (r_action != ACT_INSERT && key_rd == r_key) begin
                    if (r_action == ACT_SEARCH) begin
                        n_found = val_rd;
                    end else begin
                        key_we    = 1'b1;
                        key_wdata = KEY_DELETED;
                    end
                    n_strobe = 1'b1;
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                end else if (r_n == N_CNT) begin
                    n_strobe = 1'b1;
                    n_status = (r_action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_slot  = next_slot;
                    n_n     = r_n + 1'b1;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_slot   <= '0;
            r_n      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_n      <= n_n;
            r_strobe <= n_strobe;
        end
        r_status <= n_status;
        r_found  <= n_found;
        if (accept) begin
            r_action <= t_action'(i_action);
            r_key    <= i_entry_key;
            r_value  <= i_entry_value;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_value = r_found;

endmodule

// ----- hw/rtl/oaht_ram.sv -----
`timescale 1ns / 1ps

module oaht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/oaht_mod.sv -----
`timescale 1ns / 1ps

module oaht_mod
    import oaht_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [KEY_W-1:0]               i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_rem
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic          r_done;
            logic [AW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_rem <= i_key[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_serial
            localparam logic [AW:0] N_W = (AW+1)'(TABLE_SLOTS);

            logic                 r_busy;
            logic                 r_done;
            logic [MOD_CNT_W-1:0] r_cnt;
            logic [KEY_W-1:0]     r_shift;
            logic [AW-1:0]        r_rem;
            logic [AW:0]          t1;
            logic [AW:0]          t2;
            logic [AW-1:0]        n_rem;

            // restoring reduction, msb first, two bits per cycle
            always_comb begin
                t1 = {r_rem, r_shift[KEY_W-1]};
                if (t1 >= N_W) begin
                    t1 = t1 - N_W;
                end
                t2 = {t1[AW-1:0], r_shift[KEY_W-2]};
                if (t2 >= N_W) begin
                    t2 = t2 - N_W;
                end
                n_rem = t2[AW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                if (i_start) begin
                    r_shift <= i_key;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= {r_shift[KEY_W-3:0], 2'b00};
                    r_rem   <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

// ----- hw/rtl/oaht_checker.sv -----
`timescale 1ns / 1ps

module oaht_checker
    import oaht_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_action,
    input logic [KEY_W-1:0] i_entry_key,
    input logic             o_strobe,
    input logic [1:0]       o_status,
    input logic [VAL_W-1:0] o_found_value
);

    logic accept;
    logic key_reserved;

    assign accept       = start && !busy;
    assign key_reserved = (i_entry_key == KEY_EMPTY) || (i_entry_key == KEY_DELETED);

    // a result always lands with the block ready for the next request
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_DONE) |-> (o_found_value == '0))
        else $error("found value nonzero on failed request");

    a_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action != ACT_NOP && key_reserved)
            |=> (o_strobe && o_status == ST_RESERVED))
        else $error("reserved key not rejected at once");

    a_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_NOP)
            |=> (o_strobe && o_status == ST_DONE && o_found_value == '0))
        else $error("no-op request answered wrongly");

    // a probing request holds busy until its result
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action != ACT_NOP && !key_reserved) |=> (busy && !o_strobe))
        else $error("probing request did not hold busy");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import oaht_pkg::*;

    localparam int SLOTS = 1024;
    localparam logic [63:0] SLOTS64 = 64'(SLOTS);
    localparam int RAND_ITEMS = 640;
    localparam int HOT_HOMES = 16;
    // worst case per request is a full probe pass, taken many times over
    localparam longint CYCLE_LIMIT = 30_000_000;

    typedef struct packed {
        t_action          act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_table_req;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] found;
    } t_table_rsp;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_action = 2'd0;
    logic [KEY_W-1:0] i_entry_key = '0;
    logic [VAL_W-1:0] i_entry_value = '0;
    logic             o_strobe;
    logic [1:0]       o_status;
    logic [VAL_W-1:0] o_found_value;

    open_addressing_hash_table #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_entry_key  (i_entry_key),
        .i_entry_value(i_entry_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_found_value(o_found_value)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the slot RAMs
    logic [KEY_W-1:0] slot_key [SLOTS];
    logic [VAL_W-1:0] slot_val [SLOTS];

    t_table_req pending_reqs [$];
    t_table_rsp expected_rsps [$];

    longint cycle_cnt = 0;
    int     n_accepted = 0;
    int     n_results = 0;
    int     n_errors = 0;
    int     n_hit = 0;
    int     n_miss = 0;
    int     n_full = 0;
    int     n_reserved = 0;
    int     n_removed = 0;
    int     n_nop = 0;

    t_table_req drv_req;
    t_table_req acc_req;
    t_table_rsp acc_rsp;
    t_table_rsp mon_rsp;
    bit         drv_free;
    int         idle_pct;

    function automatic t_table_rsp table_apply(t_table_req r);
        t_table_rsp  rsp;
        int unsigned slot;
        bit          stop;
        rsp.status = ST_DONE;
        rsp.found  = '0;
        slot = int'(r.key % SLOTS64);
        stop = 1'b0;
        if (r.act != ACT_NOP && (r.key == KEY_EMPTY || r.key == KEY_DELETED)) begin
            rsp.status = ST_RESERVED;
        end else if (r.act == ACT_INSERT) begin
            rsp.status = ST_FULL;
            for (int n = 1; n <= SLOTS && !stop; n++) begin
                if (slot_key[slot] == KEY_EMPTY || slot_key[slot] == KEY_DELETED) begin
                    slot_key[slot] = r.key;
                    slot_val[slot] = r.val;
                    rsp.status = ST_DONE;
                    stop = 1'b1;
                end else begin
                    slot = (slot + n) % SLOTS;
                end
            end
        end else if (r.act == ACT_SEARCH || r.act == ACT_REMOVE) begin
            rsp.status = ST_NOT_FOUND;
            // tombstones are skipped, an empty slot ends the chain
            for (int n = 1; n <= SLOTS && !stop; n++) begin
                if (slot_key[slot] == KEY_EMPTY) begin
                    stop = 1'b1;
                end else if (slot_key[slot] == r.key) begin
                    rsp.status = ST_DONE;
                    if (r.act == ACT_SEARCH)
                        rsp.found = slot_val[slot];
                    else
                        slot_key[slot] = KEY_DELETED;
                    stop = 1'b1;
                end else begin
                    slot = (slot + n) % SLOTS;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_free = !start;
            if (start && !busy) begin
                acc_req.act = t_action'(i_action);
                acc_req.key = i_entry_key;
                acc_req.val = i_entry_value;
                acc_rsp = table_apply(acc_req);
                expected_rsps.push_back(acc_rsp);
                n_accepted++;
                if (acc_req.act == ACT_NOP)
                    n_nop++;
                else if (acc_rsp.status == ST_RESERVED)
                    n_reserved++;
                else if (acc_rsp.status == ST_FULL)
                    n_full++;
                else if (acc_rsp.status == ST_NOT_FOUND)
                    n_miss++;
                else if (acc_req.act == ACT_SEARCH)
                    n_hit++;
                else if (acc_req.act == ACT_REMOVE)
                    n_removed++;
                drv_free = 1'b1;
            end
            if (drv_free) begin
                idle_pct = (n_accepted >= 600 && n_accepted < 900) ? 0 : 13;
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    drv_req = pending_reqs.pop_front();
                    start         <= 1'b1;
                    i_action      <= drv_req.act;
                    i_entry_key   <= drv_req.key;
                    i_entry_value <= drv_req.val;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_rsps.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("tb: result with nothing pending: status %0d value %h",
                             o_status, o_found_value);
            end else begin
                mon_rsp = expected_rsps.pop_front();
                if (o_status !== mon_rsp.status || o_found_value !== mon_rsp.found) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("tb: mismatch at result %0d: status exp %0d got %0d, %s %h got %h",
                                 n_results, mon_rsp.status, o_status, "value exp",
                                 mon_rsp.found, o_found_value);
                end
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: timeout after %0d cycles", cycle_cnt);
        $display("tb: FAIL");
        $finish;
    end

    task automatic push_req(t_action act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        t_table_req r;
        r.act = act;
        r.key = key;
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 15)
            return '1;
        return rand64();
    endfunction

    initial begin
        logic [KEY_W-1:0] key_pool [$];
        logic [9:0]       hot_home [HOT_HOMES];
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] fill_key;
        t_action          act;
        int               n_rand;
        int               pick;
        int               n_free;

        for (int i = 0; i < HOT_HOMES; i++)
            hot_home[i] = 10'($urandom_range(SLOTS - 1));
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i] = KEY_EMPTY;
            slot_val[i] = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, reserved keys, no-op, collision chain with tombstones
        push_req(ACT_INSERT, 64'd1, '1);
        push_req(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        push_req(ACT_SEARCH, 64'd1, '0);
        push_req(ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, '1);
        push_req(ACT_INSERT, KEY_EMPTY, rand64());
        push_req(ACT_SEARCH, KEY_EMPTY, rand64());
        push_req(ACT_REMOVE, KEY_EMPTY, rand64());
        push_req(ACT_INSERT, KEY_DELETED, rand64());
        push_req(ACT_SEARCH, KEY_DELETED, rand64());
        push_req(ACT_REMOVE, KEY_DELETED, rand64());
        push_req(ACT_NOP, KEY_EMPTY, '1);
        push_req(ACT_NOP, 64'd1, rand64());
        push_req(ACT_INSERT, 64'd5, 64'hA5A5_0000_0000_0001);
        push_req(ACT_INSERT, 64'd5 + SLOTS64, 64'hA5A5_0000_0000_0002);
        push_req(ACT_INSERT, 64'd5 + 2 * SLOTS64, 64'hA5A5_0000_0000_0003);
        push_req(ACT_REMOVE, 64'd5 + SLOTS64, '0);
        push_req(ACT_SEARCH, 64'd5 + 2 * SLOTS64, '0);
        push_req(ACT_INSERT, 64'd5 + 3 * SLOTS64, 64'hA5A5_0000_0000_0004);
        push_req(ACT_SEARCH, 64'd5 + 3 * SLOTS64, '0);
        push_req(ACT_INSERT, 64'd5, 64'hA5A5_0000_0000_0005);
        push_req(ACT_SEARCH, 64'd5, '0);
        push_req(ACT_REMOVE, 64'd5, '0);
        push_req(ACT_SEARCH, 64'd5, '0);
        push_req(ACT_REMOVE, 64'd7, '0);
        push_req(ACT_SEARCH, 64'd5 + SLOTS64, '0);
        wait_drained();

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            pick = $urandom_range(99);
            // fresh key, half of them piled onto a few home slots
            key = rand64();
            if ($urandom_range(1))
                key[9:0] = hot_home[$urandom_range(HOT_HOMES - 1)];
            if (key == KEY_EMPTY || key == KEY_DELETED)
                key = 64'h1234_5678_9ABC_DEF0;
            if (pick < 35) begin
                act = ACT_INSERT;
                if (key_pool.size() != 0 && $urandom_range(99) < 40)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                    key_pool.push_back(key);
            end else if (pick < 85) begin
                act = (pick < 65) ? ACT_SEARCH : ACT_REMOVE;
                if (key_pool.size() != 0 && $urandom_range(99) < 80)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
            end else if (pick < 93) begin
                act = t_action'($urandom_range(2));
                key = $urandom_range(1) ? KEY_EMPTY : KEY_DELETED;
            end else begin
                act = ACT_NOP;
                if ($urandom_range(3) == 0)
                    key = $urandom_range(1) ? KEY_EMPTY : KEY_DELETED;
            end
            push_req(act, key, rand_value());
            if (act != ACT_NOP)
                n_rand++;
        end

        // sender holds off until the table has settled, then fills it
        wait_drained();
        n_free = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_key[i] == KEY_EMPTY || slot_key[i] == KEY_DELETED)
                n_free++;
        fill_key = 64'hC0FF_EE00_0000_0000 | 64'($urandom);
        push_req(ACT_INSERT, fill_key, rand_value());
        for (int i = 0; i < n_free + 1; i++) begin
            key = rand64();
            if (key == KEY_EMPTY || key == KEY_DELETED)
                key = 64'h0F0F_0F0F_0F0F_0F0F;
            push_req(ACT_INSERT, key, rand_value());
        end
        push_req(ACT_SEARCH, fill_key, '0);
        push_req(ACT_SEARCH, rand64() | 64'd1, '0);
        push_req(ACT_REMOVE, fill_key, '0);
        push_req(ACT_SEARCH, fill_key, '0);
        push_req(ACT_INSERT, fill_key ^ 64'h1, rand_value());
        push_req(ACT_INSERT, fill_key ^ 64'h2, rand_value());
        push_req(ACT_SEARCH, fill_key ^ 64'h1, '0);
        push_req(ACT_REMOVE, fill_key ^ 64'h4, '0);
        push_req(ACT_INSERT, KEY_DELETED, rand_value());

        wait_drained();
        repeat (2 * SLOTS + 8) @(negedge i_clk);

        $display("tb: %0d requests, %0d results: %0d hits, %0d removes, %0d misses",
                 n_accepted, n_results, n_hit, n_removed, n_miss);
        $display("tb: %0d table-full, %0d reserved-key, %0d no-op, %0d mismatches",
                 n_full, n_reserved, n_nop, n_errors);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- open_addressing_hash_table.f -----
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_mod.sv
hw/rtl/open_addressing_hash_table.sv
hw/rtl/oaht_checker.sv
dv/tb.sv
